@@ rtl/pqp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pqp_pkg
// shared types and constants of the pulse queue player
// ---------------------------------------------------------------------------
package pqp_pkg;

	localparam int FIFO_DEPTH_DEF    = 64;
	localparam int COUNTS_PER_US_DEF = 32;

	localparam int PERIOD_W  = 21;
	localparam int ONTIME_W  = 16;
	localparam int CURRENT_W = 8;
	localparam int TOTAL_W   = 27;
	localparam int PER_US_W  = 16;
	localparam int VOLUME_W  = 15;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 21;

	localparam logic [PERIOD_W-1:0]  PERIOD_MAX = {PERIOD_W{1'b1}};
	localparam logic [TOTAL_W-1:0]   TOTAL_MAX  = {TOTAL_W{1'b1}};
	localparam logic [CURRENT_W-1:0] CUR_MAX    = {CURRENT_W{1'b1}};

	// reset values of the configuration registers
	localparam logic [CURRENT_W-1:0] DAC_MIN_RST    = 8'd0;
	localparam logic [CURRENT_W-1:0] DAC_SPAN_RST   = 8'd255;
	localparam logic [PERIOD_W-1:0]  MIN_PERIOD_RST = 21'd32;

	typedef enum logic [1:0] {
		OP_QUEUE = 2'd0,
		OP_TICK  = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DAC_MIN    = 2'd0,
		REG_DAC_SPAN   = 2'd1,
		REG_MIN_PERIOD = 2'd2,
		REG_FIRE_EN    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]  period;
		logic [ONTIME_W-1:0]  on_time;
		logic [CURRENT_W-1:0] current;
	} pulse_t;

	localparam int PULSE_W = $bits(pulse_t);

endpackage

@@ rtl/pulse_queue_player_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pulse_queue_player_unit
// pulse fifo played out against a tick-driven timer
// ---------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one word per op: queue a pulse,
//   advance the timer by one tick, or flush. every op gives exactly one
//   result word on the output channel (out_valid/out_ready).
//   config channel (cfg_valid/cfg_ready) is always ready; write it only
//   while the block is idle.
// sequence:
//   tick without expiry, flush: from idle straight to the response state.
//   queue: push, then response; a stopped player is kickstarted by a pop.
//   tick with expiry: a pop, taken again for each zero-period entry dropped.
//   each pop uses the single fifo memory: a registered read in the pop-wait
//   state, followed by a check state.
// reset:
//   fifo empty, timer stopped, total zero, registers at their defaults.
//   fifo entries themselves are not cleared, so no clearing pass is needed.
// stall:
//   a finished result sits in the output register; the next word is taken
//   meanwhile and waits in the response state until the register frees up.
// ---------------------------------------------------------------------------
module pulse_queue_player_unit #(
	parameter int FIFO_DEPTH    = pqp_pkg::FIFO_DEPTH_DEF,
	parameter int COUNTS_PER_US = pqp_pkg::COUNTS_PER_US_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pqp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pqp_pkg::CFG_DAT_W-1:0]   cfg_data,
	// op channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      op,
	input  logic [pqp_pkg::PER_US_W-1:0]    pulse_period_us,
	input  logic [pqp_pkg::ONTIME_W-1:0]    pulse_on_time_us,
	input  logic [pqp_pkg::VOLUME_W-1:0]    pulse_volume,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            accepted,
	output logic                            fire,
	output logic [pqp_pkg::ONTIME_W-1:0]    fire_on_time,
	output logic [pqp_pkg::CURRENT_W-1:0]   fire_current,
	output logic [pqp_pkg::TOTAL_W-1:0]     buffered_counts,
	output logic                            running
);
	import pqp_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	// period conversion product, kept wide enough to see saturation
	localparam int PER_PROD_W = PER_US_W + $clog2(COUNTS_PER_US + 1);
	localparam int PER_EXT_W  = (PER_PROD_W > PERIOD_W) ? PER_PROD_W : PERIOD_W + 1;
	localparam int VPROD_W    = VOLUME_W + CURRENT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_POP_WAIT,
		ST_POP_CHK,
		ST_RESP
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CURRENT_W-1:0] dac_min_q;
	logic [CURRENT_W-1:0] dac_span_q;
	logic [PERIOD_W-1:0]  min_period_q;
	logic                 fire_en_q;

	// player state
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [CNT_W-1:0]    count_q;
	pulse_t              held_q;
	logic [PERIOD_W-1:0] tick_q;
	logic                running_q;
	logic [TOTAL_W-1:0]  total_q;

	// per-op working registers
	logic [PERIOD_W-1:0] period_q;
	logic [ONTIME_W-1:0] on_time_q;
	logic [VPROD_W-1:0]  vol_prod_s1;
	logic                expire_mode_q;
	logic                res_accepted_q;
	logic                res_fire_q;
	logic [ONTIME_W-1:0] res_on_q;
	logic [CURRENT_W-1:0] res_cur_q;

	// fifo memory
	logic [PULSE_W-1:0] fifo_mem [FIFO_DEPTH];
	logic [PULSE_W-1:0] rd_data_s1;
	logic               mem_we;
	pulse_t             push_pulse;
	pulse_t             head_pulse;

	// combinational helpers
	logic [PER_EXT_W-1:0] per_prod;
	logic [PERIOD_W-1:0]  per_sat;
	logic [CURRENT_W:0]   cur_sum;
	logic [TOTAL_W:0]     total_add;
	logic [PERIOD_W-1:0]  tick_inc;
	logic                 fifo_full;
	logic [PTR_W-1:0]     wr_ptr_nxt;
	logic [PTR_W-1:0]     rd_ptr_nxt;
	logic                 in_fire;
	logic                 tick_expire;
	logic                 fire_now;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;

	// period in counts, saturating at the timer width
	assign per_prod = PER_EXT_W'(pulse_period_us) * PER_EXT_W'(COUNTS_PER_US);
	assign per_sat  = (per_prod > PER_EXT_W'(PERIOD_MAX)) ? PERIOD_MAX
	                                                      : per_prod[PERIOD_W-1:0];

	// dac current from the registered volume product
	assign cur_sum = {1'b0, dac_min_q} + {1'b0, vol_prod_s1[VPROD_W-1:VOLUME_W]};

	assign push_pulse.period  = period_q;
	assign push_pulse.on_time = on_time_q;
	assign push_pulse.current = cur_sum[CURRENT_W] ? CUR_MAX : cur_sum[CURRENT_W-1:0];

	assign fifo_full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign mem_we     = (state_q == ST_PUSH) && !fifo_full;
	assign total_add  = {1'b0, total_q} + (TOTAL_W+1)'(period_q);
	assign tick_inc   = (tick_q != PERIOD_MAX) ? tick_q + 1'b1 : tick_q;
	assign wr_ptr_nxt = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_ptr_nxt = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign head_pulse = pulse_t'(rd_data_s1);

	// a tick word that runs the held pulse out, and whether that pulse is commanded
	assign tick_expire = running_q && (op_t'(op) == OP_TICK) && (tick_inc >= held_q.period);
	assign fire_now    = tick_expire && held_q.current != '0 && held_q.on_time != '0
	                     && fire_en_q;

	// fifo storage: one write port, one registered read port at the head
	always_ff @(posedge clk) begin
		if (mem_we) begin
			fifo_mem[wr_ptr_q] <= push_pulse;
		end
		rd_data_s1 <= fifo_mem[rd_ptr_q];
	end

	// volume times span, registered before the add and saturate
	always_ff @(posedge clk) begin
		if (in_fire) begin
			vol_prod_s1 <= VPROD_W'(pulse_volume) * VPROD_W'(dac_span_q);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dac_min_q    <= DAC_MIN_RST;
			dac_span_q   <= DAC_SPAN_RST;
			min_period_q <= MIN_PERIOD_RST;
			fire_en_q    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DAC_MIN:    dac_min_q    <= cfg_data[CURRENT_W-1:0];
				REG_DAC_SPAN:   dac_span_q   <= cfg_data[CURRENT_W-1:0];
				REG_MIN_PERIOD: min_period_q <= cfg_data[PERIOD_W-1:0];
				REG_FIRE_EN:    fire_en_q    <= cfg_data[0];
			endcase
		end
	end

	// sequencer: state, player registers and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			rd_ptr_q        <= '0;
			wr_ptr_q        <= '0;
			count_q         <= '0;
			held_q          <= '0;
			tick_q          <= '0;
			running_q       <= 1'b0;
			total_q         <= '0;
			period_q        <= '0;
			on_time_q       <= '0;
			expire_mode_q   <= 1'b0;
			res_accepted_q  <= 1'b0;
			res_fire_q      <= 1'b0;
			res_on_q        <= '0;
			res_cur_q       <= '0;
			out_valid       <= 1'b0;
			accepted        <= 1'b0;
			fire            <= 1'b0;
			fire_on_time    <= '0;
			fire_current    <= '0;
			buffered_counts <= '0;
			running         <= 1'b0;
		end else begin
			// in the response state the new word takes over the register
			if (out_valid && out_ready && state_q != ST_RESP) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_accepted_q <= 1'b0;
						// expiry: command the held pulse, then pop
						res_fire_q     <= fire_now;
						res_on_q       <= fire_now ? held_q.on_time : '0;
						res_cur_q      <= fire_now ? held_q.current : '0;
						period_q       <= per_sat;
						on_time_q      <= pulse_on_time_us;
						expire_mode_q  <= tick_expire;
						unique case (op_t'(op))
							OP_QUEUE: state_q <= ST_PUSH;
							OP_TICK: begin
								if (running_q) begin
									tick_q <= tick_inc;
									if (tick_expire) begin
										state_q <= ST_POP_WAIT;
									end else begin
										state_q <= ST_RESP;
									end
								end else begin
									state_q <= ST_RESP;
								end
							end
							OP_FLUSH: begin
								rd_ptr_q  <= '0;
								wr_ptr_q  <= '0;
								count_q   <= '0;
								total_q   <= '0;
								running_q <= 1'b0;
								tick_q    <= '0;
								state_q   <= ST_RESP;
							end
							OP_NONE: state_q <= ST_RESP;
						endcase
					end
				end

				ST_PUSH: begin
					if (!fifo_full) begin
						wr_ptr_q       <= wr_ptr_nxt;
						count_q        <= count_q + 1'b1;
						total_q        <= total_add[TOTAL_W] ? TOTAL_MAX
						                                     : total_add[TOTAL_W-1:0];
						res_accepted_q <= 1'b1;
					end
					// kickstart a stopped player when anything is waiting
					if (!running_q && (!fifo_full || count_q != '0)) begin
						state_q <= ST_POP_WAIT;
					end else begin
						state_q <= ST_RESP;
					end
				end

				// head entry is being read at rd_ptr_q
				ST_POP_WAIT: state_q <= ST_POP_CHK;

				ST_POP_CHK: begin
					if (count_q == '0) begin
						if (expire_mode_q) begin
							running_q <= 1'b0;
							tick_q    <= '0;
							total_q   <= '0;
						end
						state_q <= ST_RESP;
					end else begin
						rd_ptr_q <= rd_ptr_nxt;
						count_q  <= count_q - 1'b1;
						if (expire_mode_q && head_pulse.period == '0) begin
							// zero period at expiry: drop it, keep it as held, try again
							held_q.period  <= PERIOD_W'(1);
							held_q.on_time <= head_pulse.on_time;
							held_q.current <= head_pulse.current;
							state_q        <= ST_POP_WAIT;
						end else begin
							total_q <= (TOTAL_W'(head_pulse.period) >= total_q) ? '0
							           : total_q - TOTAL_W'(head_pulse.period);
							held_q.period  <= (head_pulse.period < min_period_q)
							                  ? min_period_q : head_pulse.period;
							held_q.on_time <= head_pulse.on_time;
							held_q.current <= head_pulse.current;
							tick_q         <= '0;
							running_q      <= 1'b1;
							state_q        <= ST_RESP;
						end
					end
				end

				ST_RESP: begin
					if (!out_valid || out_ready) begin
						out_valid       <= 1'b1;
						accepted        <= res_accepted_q;
						fire            <= res_fire_q;
						fire_on_time    <= res_on_q;
						fire_current    <= res_cur_q;
						buffered_counts <= total_q;
						running         <= running_q;
						state_q         <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// fill level never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("fifo count above depth");

	// an empty fifo has both pointers together
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> rd_ptr_q == wr_ptr_q)
		else $error("empty fifo with pointers apart");

	// a stopped timer holds a cleared counter
	a_stopped_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> tick_q == '0)
		else $error("counter nonzero while stopped");

	// the head check always follows a read cycle
	a_pop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP_CHK |-> $past(state_q) == ST_POP_WAIT)
		else $error("head check without a fresh read");

endmodule

@@ tb/pulse_queue_player_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pulse_queue_player_checker
// watches the config, op and result channels of the pulse queue player,
// tracks the pulse fifo and playout timer on its own and compares every
// result word field by field with the word it predicted
// ---------------------------------------------------------------------------
module pulse_queue_player_checker #(
	parameter int FIFO_DEPTH    = pqp_pkg::FIFO_DEPTH_DEF,
	parameter int COUNTS_PER_US = pqp_pkg::COUNTS_PER_US_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [pqp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pqp_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [1:0]                      op,
	input  logic [pqp_pkg::PER_US_W-1:0]    pulse_period_us,
	input  logic [pqp_pkg::ONTIME_W-1:0]    pulse_on_time_us,
	input  logic [pqp_pkg::VOLUME_W-1:0]    pulse_volume,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            accepted,
	input  logic                            fire,
	input  logic [pqp_pkg::ONTIME_W-1:0]    fire_on_time,
	input  logic [pqp_pkg::CURRENT_W-1:0]   fire_current,
	input  logic [pqp_pkg::TOTAL_W-1:0]     buffered_counts,
	input  logic                            running,
	output int                              mismatch_count,
	output int                              words_outstanding
);
	import pqp_pkg::*;

	typedef struct packed {
		logic                 stored;
		logic                 fired;
		logic [ONTIME_W-1:0]  on_time;
		logic [CURRENT_W-1:0] current;
		logic [TOTAL_W-1:0]   total;
		logic                 run;
	} player_word_t;

	// shadow of the player state
	pulse_t               pulse_mem [FIFO_DEPTH];
	int unsigned          rd_ptr, wr_ptr, fill;
	pulse_t               held;
	logic [PERIOD_W-1:0]  tick_cnt;
	logic                 timer_on;
	logic [TOTAL_W-1:0]   total;
	logic [CURRENT_W-1:0] reg_dac_min, reg_dac_span;
	logic [PERIOD_W-1:0]  reg_min_period;
	logic                 reg_fire_en;

	player_word_t due_words [$];
	player_word_t want_w, got_w;

	function automatic bit fifo_take(output pulse_t p);
		if (fill == 0) return 1'b0;
		p      = pulse_mem[rd_ptr];
		rd_ptr = (rd_ptr + 1 >= FIFO_DEPTH) ? 0 : rd_ptr + 1;
		fill--;
		return 1'b1;
	endfunction

	// the loaded period leaves the buffered total before the floor is applied
	function automatic void load_pulse(input pulse_t p);
		total = (p.period >= total) ? '0 : total - p.period;
		if (p.period < reg_min_period) p.period = reg_min_period;
		held     = p;
		tick_cnt = '0;
	endfunction

	function automatic player_word_t play_op(input op_t code, input logic [PER_US_W-1:0] per_us,
			input logic [ONTIME_W-1:0] on_us, input logic [VOLUME_W-1:0] vol);
		player_word_t w;
		pulse_t       p;
		pulse_t       nxt;
		int unsigned  per_c;
		int unsigned  cur;
		bit           got;
		w = '0;
		case (code)
			OP_QUEUE: begin
				per_c     = 32'(per_us) * COUNTS_PER_US;
				cur       = 32'(reg_dac_min) + ((32'(vol) * 32'(reg_dac_span)) >> VOLUME_W);
				p.period  = (per_c > PERIOD_MAX) ? PERIOD_MAX : per_c[PERIOD_W-1:0];
				p.on_time = on_us;
				p.current = (cur > CUR_MAX) ? CUR_MAX : cur[CURRENT_W-1:0];
				if (fill < FIFO_DEPTH) begin
					pulse_mem[wr_ptr] = p;
					wr_ptr = (wr_ptr + 1 >= FIFO_DEPTH) ? 0 : wr_ptr + 1;
					fill++;
					total = (TOTAL_MAX - total < p.period) ? TOTAL_MAX : total + p.period;
					w.stored = 1'b1;
				end
				// kickstart is tried whether or not the pulse went in
				if (!timer_on && fifo_take(nxt)) begin
					load_pulse(nxt);
					timer_on = 1'b1;
				end
			end
			OP_TICK: begin
				if (timer_on) begin
					if (tick_cnt < PERIOD_MAX) tick_cnt = tick_cnt + 1'b1;
					if (tick_cnt >= held.period) begin
						if (held.current != 0 && held.on_time != 0 && reg_fire_en) begin
							w.fired   = 1'b1;
							w.on_time = held.on_time;
							w.current = held.current;
						end
						// zero-period entries are skipped but still land in the held slot
						got = 1'b0;
						while (!got && fifo_take(nxt)) begin
							if (nxt.period == 0) begin
								nxt.period = 1;
								held       = nxt;
							end else begin
								got = 1'b1;
							end
						end
						if (got) begin
							load_pulse(nxt);
						end else begin
							timer_on = 1'b0;
							tick_cnt = '0;
							total    = '0;
						end
					end
				end
			end
			OP_FLUSH: begin
				rd_ptr   = 0;
				wr_ptr   = 0;
				fill     = 0;
				total    = '0;
				timer_on = 1'b0;
				tick_cnt = '0;
			end
			default: begin
			end
		endcase
		w.total = total;
		w.run   = timer_on;
		return w;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			if (mismatch_count < 10)
				$display("[%0t] %s: expected %0d, got %0d", $realtime, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr         = 0;
			wr_ptr         = 0;
			fill           = 0;
			held           = '0;
			tick_cnt       = '0;
			timer_on       = 1'b0;
			total          = '0;
			reg_dac_min    = DAC_MIN_RST;
			reg_dac_span   = DAC_SPAN_RST;
			reg_min_period = MIN_PERIOD_RST;
			reg_fire_en    = 1'b1;
			mismatch_count = 0;
			due_words.delete();
			words_outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_DAC_MIN:    reg_dac_min    = cfg_data[CURRENT_W-1:0];
					REG_DAC_SPAN:   reg_dac_span   = cfg_data[CURRENT_W-1:0];
					REG_MIN_PERIOD: reg_min_period = cfg_data[PERIOD_W-1:0];
					REG_FIRE_EN:    reg_fire_en    = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				due_words.push_back(play_op(op_t'(op), pulse_period_us, pulse_on_time_us,
					pulse_volume));
			if (out_valid && out_ready) begin
				if (due_words.size() == 0) begin
					if (mismatch_count < 10)
						$display("[%0t] result word with none expected", $realtime);
					mismatch_count++;
				end else begin
					want_w = due_words.pop_front();
					got_w  = '{accepted, fire, fire_on_time, fire_current, buffered_counts,
						running};
					check_field("accepted", want_w.stored, got_w.stored);
					check_field("fire", want_w.fired, got_w.fired);
					check_field("fire_on_time", want_w.on_time, got_w.on_time);
					check_field("fire_current", want_w.current, got_w.current);
					check_field("buffered_counts", want_w.total, got_w.total);
					check_field("running", want_w.run, got_w.run);
				end
			end
			words_outstanding <= due_words.size();
		end
	end

endmodule

@@ tb/pulse_queue_player_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pulse_queue_player_unit_test
// drives queue, tick and flush words into the pulse queue player under
// several register settings, with random gaps and output stalls; a checker
// beside the block predicts and compares every result word
// ---------------------------------------------------------------------------
module pulse_queue_player_unit_test;
	import pqp_pkg::*;

	// watchdog: cycles in a row with no word moving on any channel
	localparam int WATCHDOG_LIMIT = 4000;
	// receiver hold-off window, long enough to back the block up into its input
	localparam int HOLD_START = 700;
	localparam int HOLD_LEN   = 400;
	// window with no idling on either side
	localparam int CALM_START = 4000;
	localparam int CALM_LEN   = 1200;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DAT_W-1:0]   cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [1:0]             op        = OP_NONE;
	logic [PER_US_W-1:0]    pulse_period_us  = '0;
	logic [ONTIME_W-1:0]    pulse_on_time_us = '0;
	logic [VOLUME_W-1:0]    pulse_volume     = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   accepted;
	logic                   fire;
	logic [ONTIME_W-1:0]    fire_on_time;
	logic [CURRENT_W-1:0]   fire_current;
	logic [TOTAL_W-1:0]     buffered_counts;
	logic                   running;

	int mismatch_count;
	int words_outstanding;
	int words_sent  = 0;
	int cyc         = 0;
	int rx_cycle    = 0;
	int quiet_cycles = 0;

	always #10 clk = ~clk;

	pulse_queue_player_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.pulse_period_us  (pulse_period_us),
		.pulse_on_time_us (pulse_on_time_us),
		.pulse_volume     (pulse_volume),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.accepted         (accepted),
		.fire             (fire),
		.fire_on_time     (fire_on_time),
		.fire_current     (fire_current),
		.buffered_counts  (buffered_counts),
		.running          (running)
	);

	pulse_queue_player_checker u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.op                (op),
		.pulse_period_us   (pulse_period_us),
		.pulse_on_time_us  (pulse_on_time_us),
		.pulse_volume      (pulse_volume),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.accepted          (accepted),
		.fire              (fire),
		.fire_on_time      (fire_on_time),
		.fire_current      (fire_current),
		.buffered_counts   (buffered_counts),
		.running           (running),
		.mismatch_count    (mismatch_count),
		.words_outstanding (words_outstanding)
	);

	always @(posedge clk) cyc <= cyc + 1;

	// result side: random stalls, one long hold-off, one calm stretch
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (!arst_n)
			out_ready <= 1'b0;
		else if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
			out_ready <= 1'b0;
		else if (rx_cycle >= CALM_START && rx_cycle < CALM_START + CALM_LEN)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 99) >= 9);
	end

	// watchdog: a hang on any channel ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one op word; valid stays up with the payload held until the handshake
	task automatic put_word(input op_t code, input logic [PER_US_W-1:0] per_us,
			input logic [ONTIME_W-1:0] on_us, input logic [VOLUME_W-1:0] vol);
		// random gap before the word, except in the calm stretch
		if (!(cyc >= CALM_START && cyc < CALM_START + CALM_LEN) &&
				$urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid         <= 1'b1;
		op               <= code;
		pulse_period_us  <= per_us;
		pulse_on_time_us <= on_us;
		pulse_volume     <= vol;
		do @(posedge clk); while (!in_ready);
		// the unused code only returns a status word, so it does not count
		if (code != OP_NONE) words_sent++;
	endtask

	// all four registers in one burst, valid held across the writes
	task automatic set_player(input logic [CURRENT_W-1:0] dmin, input logic [CURRENT_W-1:0] dspan,
			input logic [PERIOD_W-1:0] minp, input logic fen);
		cfg_reg_t             regs [4] = '{REG_DAC_MIN, REG_DAC_SPAN, REG_MIN_PERIOD, REG_FIRE_EN};
		logic [CFG_DAT_W-1:0] vals [4];
		vals = '{CFG_DAT_W'(dmin), CFG_DAT_W'(dspan), CFG_DAT_W'(minp), CFG_DAT_W'(fen)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// let every expected word come back, then a short pause for the block to settle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// periods lean short so the timer actually expires; a few are huge
	function automatic logic [PER_US_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return '0;
		if (r < 80) return PER_US_W'($urandom_range(1, 2));
		if (r < 93) return PER_US_W'($urandom_range(3, 20));
		if (r < 97) return PER_US_W'($urandom);
		return '1;
	endfunction

	function automatic logic [ONTIME_W-1:0] pick_on_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 15) return '1;
		return ONTIME_W'($urandom);
	endfunction

	function automatic logic [VOLUME_W-1:0] pick_volume();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		return VOLUME_W'($urandom);
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return OP_TICK;
		if (r < 85) return OP_QUEUE;
		if (r < 93) return OP_FLUSH;
		return op_t'(2'($urandom_range(0, 3)));
	endfunction

	// random traffic in bursts: fifo fills, tick runs, zero-period chains, mixed noise
	task automatic run_mix(input int n);
		int start;
		int mode;
		start = words_sent;
		while (words_sent - start < n) begin
			mode = $urandom_range(0, 9);
			if (mode <= 2) begin
				// long enough bursts run the fifo into full
				repeat ($urandom_range(8, 72))
					put_word(OP_QUEUE, pick_period(), pick_on_time(), pick_volume());
			end else if (mode <= 5) begin
				repeat ($urandom_range(10, 100))
					put_word(OP_TICK, PER_US_W'($urandom), ONTIME_W'($urandom),
						VOLUME_W'($urandom));
			end else if (mode == 6) begin
				// zero-period entries behind a real one, then ticks to pop through them
				repeat ($urandom_range(1, 6))
					put_word(OP_QUEUE, '0, pick_on_time(), pick_volume());
				put_word(OP_QUEUE, PER_US_W'($urandom_range(1, 2)), pick_on_time(),
					pick_volume());
				repeat (40)
					put_word(OP_TICK, PER_US_W'($urandom), ONTIME_W'($urandom),
						VOLUME_W'($urandom));
			end else begin
				repeat ($urandom_range(5, 30))
					put_word(pick_op(), pick_period(), pick_on_time(), pick_volume());
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: floor of one count, a dac offset that saturates the current
		set_player(8'd200, 8'd255, 21'd1, 1'b1);
		put_word(OP_NONE, '0, '0, '0);                    // status right after reset
		put_word(OP_TICK, '1, '1, '1);                    // tick while stopped
		put_word(OP_QUEUE, '0, 16'd100, '1);              // kickstart, zero period raised
		put_word(OP_QUEUE, '0, 16'd5, '0);                // zero-period entries to skip
		put_word(OP_QUEUE, '0, 16'd6, '0);
		put_word(OP_QUEUE, '1, '1, '1);                   // widest period
		put_word(OP_TICK, '0, '0, '0);                    // expiry: fire, skip, load wide one
		put_word(OP_TICK, '0, '0, '0);                    // plain count
		put_word(OP_NONE, '1, '1, '1);                    // unused code mid-play
		put_word(OP_FLUSH, '0, '0, '0);
		put_word(OP_TICK, '0, '0, '0);                    // stopped after flush
		put_word(OP_QUEUE, '0, 16'd7, 15'd1);             // kickstart again
		put_word(OP_TICK, '0, '0, '0);                    // expiry on empty fifo stops
		put_word(OP_QUEUE, '0, '0, '0);                   // zero on-time
		put_word(OP_TICK, '0, '0, '0);                    // expiry without a fire
		put_word(OP_QUEUE, 16'd1, 16'd1, 15'd1);
		put_word(OP_QUEUE, 16'd2, '1, 15'd16384);
		put_word(OP_FLUSH, '1, '1, '1);
		settle();

		// register defaults written back explicitly
		set_player(DAC_MIN_RST, DAC_SPAN_RST, MIN_PERIOD_RST, 1'b1);
		run_mix(500);
		settle();

		// top of the current range, shortest floor
		set_player(8'd255, 8'd255, 21'd1, 1'b1);
		run_mix(450);
		settle();

		// lowest current, a floor at the widest queued period, firing off
		set_player(8'd0, 8'd0, 21'd2097120, 1'b0);
		run_mix(150);
		settle();

		// firing off with expiries happening
		set_player(8'd17, 8'd128, 21'd2, 1'b0);
		run_mix(200);
		settle();

		// random setting
		set_player(CURRENT_W'($urandom), CURRENT_W'($urandom),
			PERIOD_W'($urandom_range(1, 64)), 1'($urandom));
		run_mix(500);
		settle();

		if (mismatch_count == 0 && words_outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
